>>> design/f814_pkg.sv
package f814_pkg;
    localparam int EXP_WIDTH_DEF  = 8;
    localparam int MANT_WIDTH_DEF = 14;
    localparam int PAD_BITS       = 6;
endpackage

>>> design/float_8_14_adder.sv
// An accepted input transaction is registered in each stage in turn (order, align/add, magnitude, normalize/pack).
// One transaction is accepted per cycle; the pipeline advances when not stalled.
// i_stall freezes every stage, so nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) clears the stage valid bits only.
module float_8_14_adder
    import f814_pkg::*;
#(
    parameter int EXP_WIDTH  = EXP_WIDTH_DEF,
    parameter int MANT_WIDTH = MANT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [EXP_WIDTH+MANT_WIDTH:0]     i_left_word,
    input  logic [EXP_WIDTH+MANT_WIDTH:0]     i_right_word,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [EXP_WIDTH+MANT_WIDTH:0]     o_sum_word
);
    localparam int SW = MANT_WIDTH + PAD_BITS + 2;
    localparam int MAG_BITS = MANT_WIDTH + 8;
    localparam int NORM_BITS = MANT_WIDTH + 7;
    localparam int LZW = $clog2(NORM_BITS);

    logic adv;
    assign adv = !i_stall;
    assign o_stall = i_stall;

    // stage 1: order operands, pad
    logic [EXP_WIDTH-1:0] ea, eb, n_eref, n_diff;
    logic swap;
    logic [EXP_WIDTH+MANT_WIDTH:0] rw, ow;
    logic signed [SW-1:0] n_pr, n_po;
    logic r_v1;
    logic [EXP_WIDTH-1:0] r_eref1, r_diff1;
    logic signed [SW-1:0] r_pr1, r_po1;

    function automatic logic signed [SW-1:0] pad(input logic [EXP_WIDTH+MANT_WIDTH:0] w);
        logic [SW-1:0] m;
        m = {{(SW-MANT_WIDTH-1){1'b0}}, (w[MANT_WIDTH+:EXP_WIDTH] != '0),
             w[MANT_WIDTH-1:0]} << PAD_BITS;
        pad = w[EXP_WIDTH+MANT_WIDTH] ? -$signed(m) : $signed(m);
    endfunction

    always_comb begin
        ea = i_left_word[MANT_WIDTH+:EXP_WIDTH];
        eb = i_right_word[MANT_WIDTH+:EXP_WIDTH];
        swap = eb > ea;
        rw = swap ? i_right_word : i_left_word;
        ow = swap ? i_left_word : i_right_word;
        n_eref = swap ? eb : ea;
        n_diff = n_eref - (swap ? ea : eb);
        n_pr = pad(rw);
        n_po = pad(ow);
    end

    // stage 2: align and add
    logic signed [SW-1:0] shifted;
    logic signed [SW:0] n_sum;
    logic r_v2;
    logic [EXP_WIDTH-1:0] r_eref2;
    logic [SW:0] r_sum2;
    always_comb begin
        shifted = r_po1 >>> r_diff1;
        n_sum = {r_pr1[SW-1], r_pr1} + {shifted[SW-1], shifted};
    end

    // stage 3: magnitude and leading-zero count
    logic [SW:0] n_mag;
    logic [LZW-1:0] n_lz;
    logic r_v3, r_sign3;
    logic [EXP_WIDTH-1:0] r_eref3;
    logic [MAG_BITS-1:0] r_mag3;
    logic [LZW-1:0] r_lz3;
    always_comb begin
        n_mag = r_sum2[SW] ? -r_sum2 : r_sum2;
        n_lz = LZW'(NORM_BITS - 1);
        for (int k = 0; k < NORM_BITS - 1; k++) begin
            if (n_mag[k + 1]) n_lz = LZW'(NORM_BITS - 2 - k);
        end
    end

    // stage 4: normalize and pack
    logic [NORM_BITS-1:0] narrow;
    logic [EXP_WIDTH+MANT_WIDTH:0] n_out;
    logic r_v4;
    logic [EXP_WIDTH+MANT_WIDTH:0] r_out4;
    always_comb begin
        narrow = r_mag3[NORM_BITS-1:0] << r_lz3;
        if (r_mag3[MAG_BITS-1]) begin
            n_out = {r_sign3, r_eref3 + EXP_WIDTH'(1), r_mag3[7 +: MANT_WIDTH]};
        end else if (r_mag3 == '0) begin
            n_out = '0;
        end else begin
            n_out = {r_sign3, r_eref3 - EXP_WIDTH'(r_lz3), narrow[PAD_BITS +: MANT_WIDTH]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_eref1 <= n_eref;
            r_diff1 <= n_diff;
            r_pr1   <= n_pr;
            r_po1   <= n_po;
            r_eref2 <= r_eref1;
            r_sum2  <= n_sum;
            r_sign3 <= r_sum2[SW];
            r_eref3 <= r_eref2;
            r_mag3  <= n_mag[MAG_BITS-1:0];
            r_lz3   <= n_lz;
            r_out4  <= n_out;
        end
    end

    assign o_valid = r_v4;
    assign o_sum_word = r_out4;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stall |=> $stable(r_v4) && $stable(r_v3) && $stable(r_v1))
        else $error("pipeline moved while stalled");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |=> r_v2 == $past(r_v1))
        else $error("valid lost in stage 2");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_stall && r_mag3 == '0) |=> r_out4 == '0)
        else $error("zero sum not positive zero");
endmodule
